### sv/hrd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hrd_pkg
// Shared types, constants and helpers of the http response deframer.
// ----------------------------------------------------------------------------
package hrd_pkg;

  // body phases, one-hot
  typedef enum logic [6:0] {
    PH_HEADER  = 7'b0000001,
    PH_IDENT   = 7'b0000010,
    PH_SIZE    = 7'b0000100,
    PH_LFSKIP  = 7'b0001000,
    PH_DATA    = 7'b0010000,
    PH_TRAIL   = 7'b0100000,
    PH_DISCARD = 7'b1000000
  } phase_e;

  localparam logic KIND_PAYLOAD  = 1'b0;
  localparam logic KIND_COMPLETE = 1'b1;

  localparam int unsigned LEN_N  = 15;
  localparam int unsigned CHK_N  = 26;
  localparam int unsigned HTTP_N = 7;

  localparam logic [LEN_N*8-1:0]  PAT_LEN  = "Content-Length:";
  localparam logic [CHK_N*8-1:0]  PAT_CHK  = "Transfer-Encoding: chunked";
  localparam logic [HTTP_N*8-1:0] PAT_HTTP = "HTTP/1.";

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X_LO  = 8'h78;
  localparam logic [7:0] CH_X_UP  = 8'h58;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_T     = 8'h54;

  localparam int unsigned FIFO_DEPTH = 4;

  typedef struct packed {
    logic               chunked_mode;
    logic               failed;
    logic [31:0]        byte_count;
    logic signed [15:0] resp_status;
    logic [7:0]         data_byte;
    logic               kind;
  } hrd_result_t;

  typedef struct packed {
    logic signed [15:0] status_value;
    logic [31:0]        length_value;
    logic               chunked_flag;
  } hrd_hdr_t;

  function automatic logic is_space(input logic [7:0] b);
    return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  // 16 marks a non-hex character
  function automatic logic [4:0] hex_val(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd16;
    if (b >= 8'h30 && b <= 8'h39) r = 5'(b - 8'h30);
    else if (b >= 8'h41 && b <= 8'h46) r = 5'(b - 8'h37);
    else if (b >= 8'h61 && b <= 8'h66) r = 5'(b - 8'h57);
    return r;
  endfunction

endpackage
`default_nettype wire

### sv/http_response_deframer.sv
`default_nettype none
// a result is written into the result queue when its request is taken and is offered from it in order
// throughput: one request per cycle while the queue has room; an identity byte that ends the
//   body yields two results, drained from a four-entry result queue one per ready cycle
// input is taken while the queue has room for two results
// reset (async, active low) returns to header parsing; identity_limit to 1048576
// ----------------------------------------------------------------------------
// http_response_deframer
// Header check and matchers, identity or chunked body delivery, completion.
// ----------------------------------------------------------------------------
module http_response_deframer #(
  parameter int unsigned HEADER_CAPACITY = 8192,
  parameter int unsigned SIZE_LINE_MAX   = 63
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [7:0]  s_axis_tdata,   // byte_value
  input  wire         s_axis_tlast,   // end_of_stream
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [63:0] m_axis_tdata,   // data_byte, resp_status, byte_count, failed, chunked_mode
  output logic        m_axis_tuser,   // kind
  input  wire         cfg_we_i,
  input  wire  [31:0] cfg_wdata_i
);

  localparam int unsigned HCW = $clog2(HEADER_CAPACITY);
  localparam int unsigned LLW = $clog2(SIZE_LINE_MAX + 1);

  hrd_pkg::phase_e phase_q, phase_d;
  logic [HCW-1:0]  hcnt_q, hcnt_d, hcnt_inc;
  logic [23:0]     last3_q, last3_d;
  logic            text_end_q, text_end_d;
  logic [31:0]     recv_q, recv_d, recv_inc;
  logic [LLW-1:0]  line_q, line_d, line_inc;
  logic [31:0]     chunk_q, chunk_d, chunk_new, target, chunk_dec;
  logic [2:0]      hex_q, hex_d;
  logic [1:0]      skip_q, skip_d, skip_dec;
  logic [31:0]     limit_q;

  logic            acc, feed, mclr, push0, push1, room2, nonempty;
  logic [7:0]      b;
  logic [4:0]      h;
  logic            h_ok;
  hrd_pkg::hrd_result_t res0, res1, head, done_r, fail_r, pay_r;
  hrd_pkg::hrd_hdr_t    hdr;

  assign b    = s_axis_tdata;
  assign h    = hrd_pkg::hex_val(b);
  assign h_ok = (h != 5'd16);
  assign acc  = s_axis_tvalid & s_axis_tready;
  assign s_axis_tready = room2;

  assign hcnt_inc  = hcnt_q + HCW'(1);
  assign recv_inc  = (recv_q == '1) ? recv_q : recv_q + 32'd1;
  assign line_inc  = line_q + LLW'(1);
  assign chunk_dec = chunk_q - 32'd1;
  assign skip_dec  = (skip_q != 2'd0) ? skip_q - 2'd1 : 2'd0;
  assign target    = (hdr.length_value != '0) ? hdr.length_value
                   : (limit_q != '0) ? limit_q - 32'd1 : 32'd0;

  always_comb begin
    fail_r = '0;
    fail_r.kind   = hrd_pkg::KIND_COMPLETE;
    fail_r.failed = 1'b1;
    done_r = '0;
    done_r.kind         = hrd_pkg::KIND_COMPLETE;
    done_r.resp_status  = hdr.status_value;
    done_r.byte_count   = recv_q;
    done_r.chunked_mode = hdr.chunked_flag;
    pay_r = '0;
    pay_r.kind      = hrd_pkg::KIND_PAYLOAD;
    pay_r.data_byte = b;
  end

  // chunk size line digit accumulation
  always_comb begin
    chunk_new = chunk_q;
    hex_d     = hex_q;
    unique case (hex_q)
      3'd0: begin
        if (hrd_pkg::is_space(b)) hex_d = 3'd0;
        else if (b == hrd_pkg::CH_PLUS) hex_d = 3'd1;
        else if (b == hrd_pkg::CH_MINUS) begin chunk_new = '0; hex_d = 3'd6; end
        else if (b == hrd_pkg::CH_ZERO) hex_d = 3'd2;
        else if (h_ok) begin chunk_new = 32'(h[3:0]); hex_d = 3'd4; end
        else hex_d = 3'd5;
      end
      3'd1: begin
        if (b == hrd_pkg::CH_ZERO) hex_d = 3'd2;
        else if (h_ok) begin chunk_new = 32'(h[3:0]); hex_d = 3'd4; end
        else hex_d = 3'd5;
      end
      3'd2: begin
        if (b == hrd_pkg::CH_X_LO || b == hrd_pkg::CH_X_UP) hex_d = 3'd3;
        else if (h_ok) begin chunk_new = 32'(h[3:0]); hex_d = 3'd4; end
        else hex_d = 3'd5;
      end
      3'd3, 3'd4: begin
        if (h_ok) begin
          chunk_new = (chunk_q[31:28] != 4'd0) ? '1 : {chunk_q[27:0], h[3:0]};
          hex_d = 3'd4;
        end else hex_d = 3'd5;
      end
      default: hex_d = hex_q;
    endcase
  end

  always_comb begin
    phase_d = phase_q; hcnt_d = hcnt_q; last3_d = last3_q; text_end_d = text_end_q;
    recv_d = recv_q; line_d = line_q; chunk_d = chunk_q; skip_d = skip_q;
    feed = 1'b0; mclr = 1'b0; push0 = 1'b0; push1 = 1'b0;
    res0 = pay_r; res1 = done_r;
    if (acc) begin
      if (s_axis_tlast) begin
        if (phase_q == hrd_pkg::PH_HEADER) begin
          res0 = fail_r; push0 = 1'b1;
        end else if (phase_q != hrd_pkg::PH_DISCARD) begin
          res0 = done_r; push0 = 1'b1;
        end
        phase_d = hrd_pkg::PH_HEADER; hcnt_d = '0; last3_d = '0; text_end_d = 1'b0;
        recv_d = '0; line_d = '0; chunk_d = '0; skip_d = '0; mclr = 1'b1;
      end else begin
        unique case (phase_q)
          hrd_pkg::PH_HEADER: begin
            if (!text_end_q) begin
              if (b == 8'h00) text_end_d = 1'b1;
              else feed = 1'b1;
            end
            hcnt_d = hcnt_inc;
            if (last3_q == {hrd_pkg::CH_CR, hrd_pkg::CH_LF, hrd_pkg::CH_CR}
                && b == hrd_pkg::CH_LF) begin
              last3_d = '0;
              if (hdr.chunked_flag) begin
                phase_d = hrd_pkg::PH_SIZE; line_d = '0; chunk_d = '0;
              end else if (target == '0) begin
                res0 = done_r; push0 = 1'b1; phase_d = hrd_pkg::PH_DISCARD;
              end else begin
                chunk_d = target; phase_d = hrd_pkg::PH_IDENT;
              end
            end else begin
              last3_d = {last3_q[15:0], b};
              if (hcnt_inc >= HCW'(HEADER_CAPACITY - 1)) begin
                res0 = fail_r; push0 = 1'b1; phase_d = hrd_pkg::PH_DISCARD;
              end
            end
          end
          hrd_pkg::PH_IDENT: begin
            push0 = 1'b1; recv_d = recv_inc;
            if (recv_inc >= chunk_q) begin
              res1.byte_count = recv_inc; push1 = 1'b1; phase_d = hrd_pkg::PH_DISCARD;
            end
          end
          hrd_pkg::PH_SIZE: begin
            if (b == hrd_pkg::CH_CR) phase_d = hrd_pkg::PH_LFSKIP;
            else begin
              chunk_d = chunk_new; line_d = line_inc;
              if (line_inc >= LLW'(SIZE_LINE_MAX)) begin
                if (chunk_new == '0) begin
                  res0 = done_r; push0 = 1'b1; phase_d = hrd_pkg::PH_DISCARD;
                end else phase_d = hrd_pkg::PH_DATA;
              end
            end
          end
          hrd_pkg::PH_LFSKIP: begin
            if (chunk_q == '0) begin
              res0 = done_r; push0 = 1'b1; phase_d = hrd_pkg::PH_DISCARD;
            end else phase_d = hrd_pkg::PH_DATA;
          end
          hrd_pkg::PH_DATA: begin
            push0 = 1'b1; recv_d = recv_inc; chunk_d = chunk_dec;
            if (chunk_dec == '0) begin phase_d = hrd_pkg::PH_TRAIL; skip_d = 2'd2; end
          end
          hrd_pkg::PH_TRAIL: begin
            skip_d = skip_dec;
            if (skip_dec == 2'd0) begin
              phase_d = hrd_pkg::PH_SIZE; line_d = '0; chunk_d = '0;
            end
          end
          hrd_pkg::PH_DISCARD: phase_d = phase_q;
          default: phase_d = phase_q;
        endcase
      end
    end
  end

  // hex step restarts on every new size line and on stream end
  logic [2:0] hex_next;
  always_comb begin
    hex_next = hex_q;
    if (acc) begin
      if (s_axis_tlast) hex_next = '0;
      else if (phase_d == hrd_pkg::PH_SIZE && phase_q != hrd_pkg::PH_SIZE) hex_next = '0;
      else if (phase_q == hrd_pkg::PH_SIZE && b != hrd_pkg::CH_CR) hex_next = hex_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= hrd_pkg::PH_HEADER; hcnt_q <= '0; last3_q <= '0; text_end_q <= 1'b0;
      recv_q <= '0; line_q <= '0; chunk_q <= '0; hex_q <= '0; skip_q <= '0;
      limit_q <= 32'd1048576;
    end else begin
      phase_q <= phase_d; hcnt_q <= hcnt_d; last3_q <= last3_d; text_end_q <= text_end_d;
      recv_q <= recv_d; line_q <= line_d; chunk_q <= chunk_d; hex_q <= hex_next;
      skip_q <= skip_d;
      if (cfg_we_i) limit_q <= cfg_wdata_i;
    end
  end

  hrd_hdr_match u_match (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (mclr),
    .feed_i  (feed),
    .byte_i  (b),
    .hdr_o   (hdr)
  );

  hrd_out_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push0_i    (push0),
    .push1_i    (push1),
    .res0_i     (res0),
    .res1_i     (res1),
    .pop_i      (m_axis_tvalid & m_axis_tready),
    .head_o     (head),
    .nonempty_o (nonempty),
    .room2_o    (room2)
  );

  assign m_axis_tvalid = nonempty;
  assign m_axis_tuser  = head.kind;
  assign m_axis_tdata  = {6'd0, head.chunked_mode, head.failed, head.byte_count,
                          head.resp_status, head.data_byte};

endmodule
`default_nettype wire

### sv/hrd_hdr_match.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hrd_hdr_match
// Status, content length and chunked-encoding matchers on header text.
// ----------------------------------------------------------------------------
module hrd_hdr_match (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              clear_i,
  input  wire              feed_i,
  input  wire  [7:0]       byte_i,
  output hrd_pkg::hrd_hdr_t hdr_o
);

  logic [3:0]         st_q, st_d;
  logic signed [15:0] sv_q, sv_d;
  logic [4:0]         li_q, li_d;
  logic [31:0]        lv_q, lv_d;
  logic [4:0]         ci_q, ci_d;
  logic               cf_q, cf_d;

  logic               dg, sp;
  logic [3:0]         dv;
  logic signed [20:0] up10, dn10;
  logic [35:0]        lacc;
  logic [7:0]         http_c, len_c, chk_c;

  assign dg   = hrd_pkg::is_digit(byte_i);
  assign sp   = hrd_pkg::is_space(byte_i);
  assign dv   = byte_i[3:0];
  assign up10 = 21'(sv_q) * 21'sd10 + 21'(signed'({1'b0, dv}));
  assign dn10 = 21'(sv_q) * 21'sd10 - 21'(signed'({1'b0, dv}));
  assign lacc = {4'd0, lv_q} * 36'd10 + {32'd0, dv};
  assign http_c = hrd_pkg::PAT_HTTP[8*(hrd_pkg::HTTP_N-1-32'(st_q[2:0])) +: 8];
  assign len_c  = hrd_pkg::PAT_LEN[8*(hrd_pkg::LEN_N-1-32'(li_q)) +: 8];
  assign chk_c  = hrd_pkg::PAT_CHK[8*(hrd_pkg::CHK_N-1-32'(ci_q)) +: 8];

  always_comb begin
    st_d = st_q; sv_d = sv_q; li_d = li_q; lv_d = lv_q; ci_d = ci_q; cf_d = cf_q;
    if (clear_i) begin
      st_d = '0; sv_d = '0; li_d = '0; lv_d = '0; ci_d = '0; cf_d = 1'b0;
    end else if (feed_i) begin
      // status line "HTTP/1.<int> <int>"
      priority if (st_q < 4'd7) begin
        st_d = (byte_i == http_c) ? st_q + 4'd1 : 4'd15;
      end else if (st_q == 4'd7) begin
        st_d = sp ? 4'd7 : (byte_i == hrd_pkg::CH_PLUS || byte_i == hrd_pkg::CH_MINUS) ? 4'd8
             : dg ? 4'd9 : 4'd15;
      end else if (st_q == 4'd8) begin
        st_d = dg ? 4'd9 : 4'd15;
      end else if (st_q == 4'd9 || st_q == 4'd10) begin
        if (dg && st_q == 4'd10) begin
          sv_d = 16'(dv); st_d = 4'd12;
        end else if (dg) st_d = 4'd9;
        else if (sp) st_d = 4'd10;
        else st_d = (byte_i == hrd_pkg::CH_PLUS) ? 4'd11
                  : (byte_i == hrd_pkg::CH_MINUS) ? 4'd13 : 4'd15;
      end else if (st_q == 4'd11 || st_q == 4'd13) begin
        if (dg) begin
          sv_d = (st_q == 4'd11) ? 16'(dv) : -16'(dv);
          st_d = st_q + 4'd1;
        end else st_d = 4'd15;
      end else if (st_q == 4'd12) begin
        if (dg) sv_d = (up10 > 21'sd32767) ? 16'sd32767 : up10[15:0];
        else st_d = 4'd15;
      end else if (st_q == 4'd14) begin
        if (dg) sv_d = (dn10 < -21'sd32768) ? -16'sd32768 : dn10[15:0];
        else st_d = 4'd15;
      end else begin
        st_d = st_q;
      end

      // content length
      priority if (li_q < 5'd15) begin
        li_d = (byte_i == len_c) ? li_q + 5'd1 : (byte_i == hrd_pkg::CH_C ? 5'd1 : 5'd0);
      end else if (li_q == 5'd15) begin
        if (sp) li_d = 5'd15;
        else if (byte_i == hrd_pkg::CH_PLUS) li_d = 5'd16;
        else if (dg) begin lv_d = 32'(dv); li_d = 5'd17; end
        else li_d = 5'd18;
      end else if (li_q == 5'd16) begin
        if (dg) begin lv_d = 32'(dv); li_d = 5'd17; end
        else li_d = 5'd18;
      end else if (li_q == 5'd17) begin
        if (dg) lv_d = (lacc[35:32] != 4'd0) ? '1 : lacc[31:0];
        else li_d = 5'd18;
      end else begin
        li_d = li_q;
      end

      // chunked transfer encoding
      if (ci_q < 5'd26) begin
        ci_d = (byte_i == chk_c) ? ci_q + 5'd1 : (byte_i == hrd_pkg::CH_T ? 5'd1 : 5'd0);
        if (ci_d == 5'd26) cf_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0; sv_q <= '0; li_q <= '0; lv_q <= '0; ci_q <= '0; cf_q <= 1'b0;
    end else begin
      st_q <= st_d; sv_q <= sv_d; li_q <= li_d; lv_q <= lv_d; ci_q <= ci_d; cf_q <= cf_d;
    end
  end

  assign hdr_o.status_value = sv_q;
  assign hdr_o.length_value = lv_q;
  assign hdr_o.chunked_flag = cf_q;

endmodule
`default_nettype wire

### sv/hrd_out_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hrd_out_fifo
// Small result queue: up to two pushes and one pop per cycle.
// ----------------------------------------------------------------------------
module hrd_out_fifo (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push0_i,
  input  wire                  push1_i,
  input  hrd_pkg::hrd_result_t res0_i,
  input  hrd_pkg::hrd_result_t res1_i,
  input  wire                  pop_i,
  output hrd_pkg::hrd_result_t head_o,
  output logic                 nonempty_o,
  output logic                 room2_o
);

  localparam int unsigned PW = $clog2(hrd_pkg::FIFO_DEPTH);
  localparam int unsigned CW = $clog2(hrd_pkg::FIFO_DEPTH + 1);

  hrd_pkg::hrd_result_t mem_q [hrd_pkg::FIFO_DEPTH];
  logic [PW-1:0] wr_q, rd_q, wr1;
  logic [CW-1:0] cnt_q;

  assign wr1        = wr_q + PW'(1);
  assign head_o     = mem_q[rd_q];
  assign nonempty_o = (cnt_q != '0);
  assign room2_o    = (cnt_q <= CW'(hrd_pkg::FIFO_DEPTH - 2));

  always_ff @(posedge clk_i) begin
    if (push0_i) mem_q[wr_q] <= res0_i;
    if (push1_i) mem_q[wr1] <= res1_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + PW'(push0_i) + PW'(push1_i);
      rd_q  <= rd_q + PW'(pop_i);
      cnt_q <= cnt_q + CW'(push0_i) + CW'(push1_i) - CW'(pop_i);
    end
  end

endmodule
`default_nettype wire

### sv/hrd_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hrd_props
// Port-level checks of the deframer, bound to the top level.
// ----------------------------------------------------------------------------
module hrd_props (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        s_axis_tready,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [63:0] m_axis_tdata,
  input wire        m_axis_tuser
);

  // payload results carry nothing but the byte
  a_payload_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == 1'b0) |-> (m_axis_tdata[63:8] == '0))
    else $error("payload result with completion fields set");

  // a failed completion reports no status, count or chunking
  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser && m_axis_tdata[56]) |->
      (m_axis_tdata[55:0] == '0 && m_axis_tdata[57] == 1'b0))
    else $error("failed completion with data");

  // input stalls only behind queued results
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with empty output");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("output request withdrawn");

endmodule

bind http_response_deframer hrd_props u_hrd_props (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

### verif/hrd_checker.sv
// ----------------------------------------------------------------------------
// hrd_checker
// Watches the byte stream, the result stream and the register write port of
// the http response deframer, predicts every result and compares it.
// ----------------------------------------------------------------------------
module hrd_checker (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_tvalid_i,
  input  wire         s_tready_i,
  input  wire  [7:0]  s_tdata_i,
  input  wire         s_tlast_i,
  input  wire         m_tvalid_i,
  input  wire         m_tready_i,
  input  wire  [63:0] m_tdata_i,
  input  wire         m_tuser_i,
  input  wire         cfg_we_i,
  input  wire  [31:0] cfg_wdata_i,
  output int          fail_count_o,
  output int          pending_o
);

  localparam int unsigned HDR_CAP  = 8192;
  localparam int unsigned LINE_MAX = 63;
  localparam logic [31:0] SAT32    = 32'hFFFF_FFFF;

  hrd_pkg::hrd_result_t expected_q[$];

  hrd_pkg::phase_e ph;
  int unsigned hdr_cnt;
  logic [23:0] tail;
  int          st_step;
  int          st_val;
  int          len_idx;
  logic [31:0] len_val;
  int          chk_idx;
  bit          chk_flag;
  logic [31:0] rx_cnt;
  int          line_len;
  logic [31:0] chunk_rem;
  int          hex_step;
  int          skip_left;
  bit          text_end;
  logic [31:0] id_limit;

  function automatic bit ws(logic [7:0] b);
    return b == 8'd32 || (b >= 8'd9 && b <= 8'd13);
  endfunction

  function automatic bit dec(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic int hexd(logic [7:0] b);
    if (b >= "0" && b <= "9") return b - "0";
    if (b >= "A" && b <= "F") return b - "A" + 10;
    if (b >= "a" && b <= "f") return b - "a" + 10;
    return 16;
  endfunction

  function automatic logic [31:0] acc_sat(logic [31:0] v, int base, int d);
    longint unsigned t;
    t = longint'(v) * base + d;
    return (t > SAT32) ? SAT32 : t[31:0];
  endfunction

  function automatic string res_text(hrd_pkg::hrd_result_t r);
    return $sformatf("kind=%0d data=%h status=%0d count=%0d fail=%0d chk=%0d",
                     r.kind, r.data_byte, r.resp_status, r.byte_count,
                     r.failed, r.chunked_mode);
  endfunction

  task automatic clear_all();
    ph = hrd_pkg::PH_HEADER; hdr_cnt = 0; tail = '0; st_step = 0; st_val = 0;
    len_idx = 0; len_val = '0; chk_idx = 0; chk_flag = 0; rx_cnt = '0;
    line_len = 0; chunk_rem = '0; hex_step = 0; skip_left = 0; text_end = 0;
  endtask

  task automatic push_payload(logic [7:0] b);
    hrd_pkg::hrd_result_t r;
    r = '0;
    r.kind = hrd_pkg::KIND_PAYLOAD;
    r.data_byte = b;
    expected_q.push_back(r);
    if (rx_cnt != SAT32) rx_cnt++;
  endtask

  task automatic push_done();
    hrd_pkg::hrd_result_t r;
    r = '0;
    r.kind = hrd_pkg::KIND_COMPLETE;
    r.resp_status = 16'(st_val);
    r.byte_count = rx_cnt;
    r.chunked_mode = chk_flag;
    expected_q.push_back(r);
    ph = hrd_pkg::PH_DISCARD;
  endtask

  task automatic push_fail();
    hrd_pkg::hrd_result_t r;
    r = '0;
    r.kind = hrd_pkg::KIND_COMPLETE;
    r.failed = 1'b1;
    expected_q.push_back(r);
    ph = hrd_pkg::PH_DISCARD;
  endtask

  task automatic feed_status(logic [7:0] b);
    int s;
    int d;
    int v;
    s = st_step;
    d = int'(b) - 48;
    if (s < 7) s = (b == hrd_pkg::PAT_HTTP[(hrd_pkg::HTTP_N-1-s)*8 +: 8]) ? s + 1 : 15;
    else if (s == 7) s = ws(b) ? 7 : (b == "+" || b == "-") ? 8 : dec(b) ? 9 : 15;
    else if (s == 8) s = dec(b) ? 9 : 15;
    else if (s == 9 || s == 10) begin
      if (dec(b) && s == 10) begin
        st_val = d; s = 12;
      end else if (dec(b)) s = 9;
      else if (ws(b)) s = 10;
      else s = (b == "+") ? 11 : (b == "-") ? 13 : 15;
    end else if (s == 11 || s == 13) begin
      if (dec(b)) begin
        st_val = (s == 11) ? d : -d; s = s + 1;
      end else s = 15;
    end else if (s == 12) begin
      if (dec(b)) begin
        v = st_val * 10 + d; st_val = (v > 32767) ? 32767 : v;
      end else s = 15;
    end else if (s == 14) begin
      if (dec(b)) begin
        v = st_val * 10 - d; st_val = (v < -32768) ? -32768 : v;
      end else s = 15;
    end
    st_step = s;
  endtask

  task automatic feed_length(logic [7:0] b);
    int i;
    i = len_idx;
    if (i < 15) begin
      i = (b == hrd_pkg::PAT_LEN[(hrd_pkg::LEN_N-1-i)*8 +: 8]) ? i + 1
        : (b == "C" ? 1 : 0);
    end else if (i == 15) begin
      if (ws(b)) i = 15;
      else if (b == "+") i = 16;
      else if (dec(b)) begin
        len_val = 32'(b - 8'd48); i = 17;
      end else i = 18;
    end else if (i == 16) begin
      if (dec(b)) begin
        len_val = 32'(b - 8'd48); i = 17;
      end else i = 18;
    end else if (i == 17) begin
      if (dec(b)) len_val = acc_sat(len_val, 10, int'(b) - 48);
      else i = 18;
    end
    len_idx = i;
  endtask

  task automatic feed_chunked(logic [7:0] b);
    if (chk_idx < 26) begin
      chk_idx = (b == hrd_pkg::PAT_CHK[(hrd_pkg::CHK_N-1-chk_idx)*8 +: 8]) ? chk_idx + 1
              : (b == "T" ? 1 : 0);
      if (chk_idx == 26) chk_flag = 1;
    end
  endtask

  task automatic feed_hex(logic [7:0] b);
    int h;
    h = hexd(b);
    case (hex_step)
      0: begin
        if (ws(b)) hex_step = 0;
        else if (b == "+") hex_step = 1;
        else if (b == "-") begin
          chunk_rem = '0; hex_step = 6;
        end else if (b == "0") hex_step = 2;
        else if (h < 16) begin
          chunk_rem = 32'(h); hex_step = 4;
        end else hex_step = 5;
      end
      1, 2: begin
        if (b == "0" && hex_step == 1) hex_step = 2;
        else if ((b == "x" || b == "X") && hex_step == 2) hex_step = 3;
        else if (h < 16) begin
          chunk_rem = 32'(h); hex_step = 4;
        end else hex_step = 5;
      end
      3, 4: begin
        if (h < 16) begin
          chunk_rem = acc_sat(chunk_rem, 16, h); hex_step = 4;
        end else hex_step = 5;
      end
      default: ;
    endcase
  endtask

  task automatic size_line();
    ph = hrd_pkg::PH_SIZE; line_len = 0; chunk_rem = '0; hex_step = 0;
  endtask

  task automatic size_done();
    if (chunk_rem == 0) push_done();
    else ph = hrd_pkg::PH_DATA;
  endtask

  task automatic predict(logic [7:0] b, logic eos);
    logic [31:0] target;
    if (eos) begin
      if (ph == hrd_pkg::PH_HEADER) push_fail();
      else if (ph != hrd_pkg::PH_DISCARD) push_done();
      clear_all();
      return;
    end
    case (ph)
      hrd_pkg::PH_HEADER: begin
        if (!text_end) begin
          if (b == 8'd0) text_end = 1;
          else begin
            feed_status(b); feed_length(b); feed_chunked(b);
          end
        end
        hdr_cnt++;
        if (tail == 24'h0D0A0D && b == 8'h0A) begin
          tail = '0;
          if (chk_flag) size_line();
          else begin
            target = (len_val != 0) ? len_val : (id_limit != 0 ? id_limit - 32'd1 : 32'd0);
            if (target == 0) push_done();
            else begin
              chunk_rem = target; ph = hrd_pkg::PH_IDENT;
            end
          end
        end else begin
          tail = {tail[15:0], b};
          if (hdr_cnt >= HDR_CAP - 1) push_fail();
        end
      end
      hrd_pkg::PH_IDENT: begin
        push_payload(b);
        if (rx_cnt >= chunk_rem) push_done();
      end
      hrd_pkg::PH_SIZE: begin
        if (b == 8'h0D) ph = hrd_pkg::PH_LFSKIP;
        else begin
          feed_hex(b);
          line_len++;
          if (line_len >= LINE_MAX) size_done();
        end
      end
      hrd_pkg::PH_LFSKIP: size_done();
      hrd_pkg::PH_DATA: begin
        push_payload(b);
        chunk_rem--;
        if (chunk_rem == 0) begin
          ph = hrd_pkg::PH_TRAIL; skip_left = 2;
        end
      end
      hrd_pkg::PH_TRAIL: begin
        if (skip_left > 0) skip_left--;
        if (skip_left == 0) size_line();
      end
      default: ;
    endcase
  endtask

  task automatic compare(logic [63:0] d, logic k);
    hrd_pkg::hrd_result_t got;
    hrd_pkg::hrd_result_t exp_r;
    got = '0;
    got.kind = k;
    got.data_byte = d[7:0];
    got.resp_status = d[23:8];
    got.byte_count = d[55:24];
    got.failed = d[56];
    got.chunked_mode = d[57];
    if (expected_q.size() == 0) begin
      fail_count_o++;
      if (fail_count_o <= 10) $display("unexpected result kind=%0d tdata=%h", k, d);
      return;
    end
    exp_r = expected_q.pop_front();
    if (got.kind != exp_r.kind || got.data_byte != exp_r.data_byte ||
        got.resp_status != exp_r.resp_status || got.byte_count != exp_r.byte_count ||
        got.failed != exp_r.failed || got.chunked_mode != exp_r.chunked_mode ||
        d[63:58] != '0) begin
      fail_count_o++;
      if (fail_count_o <= 10)
        $display("mismatch: exp %s / got %s", res_text(exp_r), res_text(got));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_all();
      id_limit = 32'd1048576;
      expected_q.delete();
      fail_count_o = 0;
    end else begin
      if (m_tvalid_i && m_tready_i) compare(m_tdata_i, m_tuser_i);
      if (s_tvalid_i && s_tready_i) predict(s_tdata_i, s_tlast_i);
      if (cfg_we_i) id_limit = cfg_wdata_i;
    end
    pending_o = expected_q.size();
  end

endmodule

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives http responses (identity, chunked, broken and noise) into the
// deframer under random source and sink stalls; the checker scores results.
// ----------------------------------------------------------------------------
module tb_top;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_we_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;

  int  fail_count;
  int  pending;
  bit  s_fire = 0;
  bit  no_idle = 0;
  int  sent = 0;
  longint cycles = 0;
  logic [7:0] resp_q[$];

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  http_response_deframer dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_we_i, .cfg_wdata_i
  );

  hrd_checker u_checker (
    .clk_i, .rst_ni,
    .s_tvalid_i(s_axis_tvalid), .s_tready_i(s_axis_tready),
    .s_tdata_i(s_axis_tdata), .s_tlast_i(s_axis_tlast),
    .m_tvalid_i(m_axis_tvalid), .m_tready_i(m_axis_tready),
    .m_tdata_i(m_axis_tdata), .m_tuser_i(m_axis_tuser),
    .cfg_we_i, .cfg_wdata_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) s_fire <= s_axis_tvalid && s_axis_tready;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 3_000_000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // sink stalls in bursts
  initial begin
    int n;
    forever begin
      @(negedge clk_i);
      if (!no_idle && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 12);
        m_axis_tready = 1'b0;
        repeat (n) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
    end
  end

  task automatic send(logic [7:0] b, logic eos);
    int n;
    if (!no_idle && $urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, 12);
      s_axis_tvalid = 1'b0;
      repeat (n) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = b;
    s_axis_tlast = eos;
    do @(negedge clk_i); while (!s_fire);
    s_axis_tvalid = 1'b0;
    sent++;
  endtask

  task automatic add_text(string s);
    foreach (s[i]) resp_q.push_back(s[i]);
  endtask

  task automatic add_rand(int n);
    repeat (n) resp_q.push_back(8'($urandom));
  endtask

  function automatic string hex_text(int unsigned v);
    string s;
    int unsigned d;
    s = "";
    do begin
      d = v % 16;
      if (d < 10) s = {string'(8'("0" + d)), s};
      else if ($urandom_range(0, 1)) s = {string'(8'("a" + d - 10)), s};
      else s = {string'(8'("A" + d - 10)), s};
      v = v / 16;
    end while (v != 0);
    return s;
  endfunction

  // sends the queued response, then the end-of-stream mark if with_eos is set
  task automatic flush_resp(bit with_eos);
    foreach (resp_q[i]) send(resp_q[i], 1'b0);
    resp_q.delete();
    if (with_eos) send(8'($urandom), 1'b1);
  endtask

  task automatic add_chunk(int unsigned len);
    add_text({hex_text(len), "\r\n"});
    add_rand(len);
    add_rand(2);
  endtask

  task automatic write_limit(logic [31:0] v);
    wait (pending == 0);
    repeat (4) @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_wdata_i = v;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic random_resp();
    int sel;
    int k;
    sel = $urandom_range(0, 19);
    if (sel == 0) begin
      add_rand($urandom_range(0, 20));
      flush_resp(1);
      return;
    end
    case ($urandom_range(0, 5))
      0: add_text($sformatf("HTTP/1.%0d %0d OK\r\n",
                            $urandom_range(0, 1), $urandom_range(100, 599)));
      1: add_text($sformatf("HTTP/1.1 -%0d\r\n", $urandom_range(0, 99999)));
      2: add_text($sformatf("HTTP/1.0  +%0d x\r\n", $urandom));
      3: add_text("HTTP/2.0 200\r\n");
      default: add_text($sformatf("HTTP/1.1 %0d Fine\r\n", $urandom_range(0, 40000)));
    endcase
    if ($urandom_range(0, 3) == 0)
      add_text({"X-Junk: ", string'(8'($urandom_range(33, 126))), "\r\n"});
    k = $urandom_range(0, 5);
    if (k < 3) add_text($sformatf("Content-Length: %0d\r\n", $urandom_range(0, 30)));
    else if (k == 3) add_text($sformatf("Content-Length:+%0d\r\n", $urandom_range(0, 30)));
    else if (k == 4) add_text("Content-Length: -3\r\n");
    if ($urandom_range(0, 2) == 0) begin
      add_text("Transfer-Encoding: chunked\r\n");
      add_text("\r\n");
      repeat ($urandom_range(0, 3)) add_chunk($urandom_range(1, 14));
      if ($urandom_range(0, 4) != 0) add_text("0\r\n");
    end else begin
      add_text("\r\n");
      add_rand($urandom_range(0, 35));
    end
    if (sel == 1) resp_q = resp_q[0:$urandom_range(0, resp_q.size() - 1)];
    add_rand($urandom_range(0, 3));
    flush_resp(1);
  endtask

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: plain identity body with stray bytes after it
    add_text("HTTP/1.1 200 OK\r\nContent-Length: 3\r\n\r\n");
    resp_q.push_back(8'hFF); resp_q.push_back(8'h00); resp_q.push_back(8'hA5);
    add_rand(2);
    flush_resp(1);
    // chunked with 0x prefix and a trailing zero chunk
    add_text("HTTP/1.0 404\r\nTransfer-Encoding: chunked\r\n\r\n");
    add_chunk(10);
    add_text("0x3\r\n"); add_rand(5);
    add_text("+0\r\n");
    flush_resp(1);
    // stream closes inside the header
    add_text("HTTP/1.1 20");
    flush_resp(1);
    // saturating status, negative status
    add_text("HTTP/1.0 99999\r\n\r\n"); add_rand(4); flush_resp(1);
    add_text("HTTP/1.1 -40000\r\n\r\n"); flush_resp(1);
    // zero byte stops the matchers
    add_text("HTTP/1.1 2"); resp_q.push_back(8'h00);
    add_text("Content-Length: 5\r\n\r\n"); add_rand(3); flush_resp(1);
    // negative length, negative chunk size, overflowing length
    add_text("HTTP/1.1 200\r\nContent-Length: -5\r\n\r\n"); add_rand(3); flush_resp(1);
    add_text("HTTP/1.1 200\r\nTransfer-Encoding: chunked\r\n\r\n-1\r\n");
    add_rand(2); flush_resp(1);
    add_text("HTTP/1.1 200\r\nContent-Length: 99999999999\r\n\r\n"); add_rand(6); flush_resp(1);
    // size line that never ends, stream end in chunk data
    add_text("HTTP/1.1 200\r\nTransfer-Encoding: chunked\r\n\r\n");
    repeat (62) add_text("0");
    add_text("5"); add_rand(3); flush_resp(1);

    // register extremes and random values, each followed by two responses
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: write_limit(32'd1);
        1: write_limit(32'hFFFF_FFFF);
        2: write_limit(32'd2);
        3: write_limit(32'd0);
        4: write_limit(32'd17);
        default: write_limit($urandom_range(1, 40));
      endcase
      add_text("HTTP/1.1 201\r\n\r\n"); add_rand(20); flush_resp(1);
      random_resp();
    end

    write_limit(32'd1048576);
    while (sent < 1800) begin
      if (sent > 1500) no_idle = 1;
      random_resp();
    end

    wait (pending == 0);
    repeat (20) @(negedge clk_i);
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
